/* src/bwc_pkg.sv */
// Package for the battery wake check block: queue entry type, register
// indexes, wake reason codes and the poll interval table. No dependencies.
package bwc_pkg;

    localparam int PCT_W   = 7;
    localparam int VOLT_W  = 23;
    localparam int TEMP_W  = 8;
    localparam int VOTE_W  = 3;
    localparam int POLL_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_VOLT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_VOTE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_TEMP     = 3'd7;

    localparam logic [1:0] WAKE_NONE      = 2'd0;
    localparam logic [1:0] WAKE_BAND      = 2'd1;
    localparam logic [1:0] WAKE_CRIT_BATT = 2'd2;
    localparam logic [1:0] WAKE_CRIT_TEMP = 2'd3;

    localparam logic [VOLT_W-1:0] POLL_VOLT_0 = 23'd3800000;
    localparam logic [VOLT_W-1:0] POLL_VOLT_1 = 23'd3600000;
    localparam logic [VOLT_W-1:0] POLL_VOLT_2 = 23'd3500000;
    localparam logic [VOLT_W-1:0] POLL_VOLT_3 = 23'd3400000;

    localparam int MINUTE_SECS = 60;
    localparam logic [POLL_W-1:0] POLL_SECS_0 = POLL_W'(10 * MINUTE_SECS);
    localparam logic [POLL_W-1:0] POLL_SECS_1 = POLL_W'(5 * MINUTE_SECS);
    localparam logic [POLL_W-1:0] POLL_SECS_2 = POLL_W'(1 * MINUTE_SECS);
    localparam logic [POLL_W-1:0] POLL_SECS_3 = POLL_W'(10);
    localparam logic [POLL_W-1:0] POLL_SECS_4 = POLL_W'(5);

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]        reason;
        logic [1:0]        band;
        logic [VOLT_W-1:0] volt;
        logic [TEMP_W-1:0] temp;
    } bwc_entry_t;

    function automatic logic [POLL_W-1:0] poll_lookup(input logic [VOLT_W-1:0] v);
        logic [POLL_W-1:0] secs;
        if (v >= POLL_VOLT_0) secs = POLL_SECS_0;
        else if (v >= POLL_VOLT_1) secs = POLL_SECS_1;
        else if (v >= POLL_VOLT_2) secs = POLL_SECS_2;
        else if (v >= POLL_VOLT_3) secs = POLL_SECS_3;
        else secs = POLL_SECS_4;
        return secs;
    endfunction

endpackage

/* src/bwc_front.sv */
// Front part: configuration registers, voltage ring, stored voltage, temperature
// and band; classifies each accepted reading into a queue word. Uses bwc_pkg.
module bwc_front
    import bwc_pkg::*;
#(
    parameter int VOLTAGE_WINDOW = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  accept,
    input  logic                  read_ok,
    input  logic [PCT_W-1:0]      charge_percent,
    input  logic [VOLT_W-1:0]     cell_voltage_uv,
    input  logic [TEMP_W-1:0]     cell_temp_c,
    output bwc_entry_t            entry,
    output logic [TEMP_W-1:0]     hot_temp
);

    localparam int POS_W   = $clog2(VOLTAGE_WINDOW);
    localparam int COUNT_W = $clog2(VOLTAGE_WINDOW + 1);
    localparam int CMP_W   = (COUNT_W > VOTE_W) ? COUNT_W : VOTE_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(VOLTAGE_WINDOW - 1);

    logic [PCT_W-1:0]  band_limit_reg [4];
    logic [VOLT_W-1:0] crit_volt_reg;
    logic [VOTE_W-1:0] low_vote_reg;
    logic [TEMP_W-1:0] max_temp_reg;
    logic [TEMP_W-1:0] hot_temp_reg;

    logic [VOLT_W-1:0] ring_reg [VOLTAGE_WINDOW];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VOLT_W-1:0] last_volt_reg;
    logic [TEMP_W-1:0] last_temp_reg;
    logic [1:0]        last_band_reg, band_next;

    logic [COUNT_W-1:0] low_count;
    logic [1:0]         band_calc;
    logic [1:0]         reason;
    logic [VOLT_W-1:0]  sample;

    assign pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;

    always_comb begin
        low_count = '0;
        for (int i = 0; i < VOLTAGE_WINDOW; i++) begin
            sample = (pos_next == POS_W'(i)) ? cell_voltage_uv : ring_reg[i];
            if (sample != '0 && sample <= crit_volt_reg)
                low_count = low_count + 1'b1;
        end
    end

    always_comb begin
        band_calc = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (charge_percent <= band_limit_reg[i])
                band_calc = 2'(i);
        end
    end

    always_comb begin
        reason    = WAKE_NONE;
        band_next = last_band_reg;
        if (read_ok) begin
            if (CMP_W'(low_count) >= CMP_W'(low_vote_reg)) begin
                reason = WAKE_CRIT_BATT;
            end else if ($signed(cell_temp_c) >= $signed(max_temp_reg)) begin
                reason = WAKE_CRIT_TEMP;
            end else if (band_calc != last_band_reg) begin
                reason    = WAKE_BAND;
                band_next = band_calc;
            end
        end
    end

    always_comb begin
        entry.reason = reason;
        entry.band   = band_next;
        entry.volt   = read_ok ? cell_voltage_uv : last_volt_reg;
        entry.temp   = read_ok ? cell_temp_c : last_temp_reg;
    end

    assign hot_temp = hot_temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_limit_reg[0] <= 7'd100;
            band_limit_reg[1] <= 7'd20;
            band_limit_reg[2] <= 7'd10;
            band_limit_reg[3] <= 7'd5;
            crit_volt_reg     <= 23'd3400000;
            low_vote_reg      <= 3'd3;
            max_temp_reg      <= 8'sd60;
            hot_temp_reg      <= 8'sd50;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BAND_LIMIT_0: band_limit_reg[0] <= cfg_wdata[PCT_W-1:0];
                REG_BAND_LIMIT_1: band_limit_reg[1] <= cfg_wdata[PCT_W-1:0];
                REG_BAND_LIMIT_2: band_limit_reg[2] <= cfg_wdata[PCT_W-1:0];
                REG_BAND_LIMIT_3: band_limit_reg[3] <= cfg_wdata[PCT_W-1:0];
                REG_CRIT_VOLT:    crit_volt_reg     <= cfg_wdata[VOLT_W-1:0];
                REG_LOW_VOTE:     low_vote_reg      <= cfg_wdata[VOTE_W-1:0];
                REG_MAX_TEMP:     max_temp_reg      <= cfg_wdata[TEMP_W-1:0];
                REG_HOT_TEMP:     hot_temp_reg      <= cfg_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOLTAGE_WINDOW; i++)
                ring_reg[i] <= '0;
            pos_reg       <= '0;
            last_volt_reg <= '0;
            last_temp_reg <= '0;
            last_band_reg <= 2'd0;
        end else if (accept && read_ok) begin
            ring_reg[pos_next] <= cell_voltage_uv;
            pos_reg            <= pos_next;
            last_volt_reg      <= cell_voltage_uv;
            last_temp_reg      <= cell_temp_c;
            last_band_reg      <= band_next;
        end
    end

endmodule

/* src/bwc_queue.sv */
// Short word queue between front and back parts.
// Depth from bwc_pkg::QUEUE_DEPTH; holds bwc_entry_t words.
module bwc_queue
    import bwc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  bwc_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output logic       not_empty,
    output bwc_entry_t rd_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    bwc_entry_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign fill      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

/* src/bwc_back.sv */
// Back part: poll interval lookup, hot cap and the registered result word.
// Uses bwc_pkg for the voltage table and entry type.
module bwc_back
    import bwc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  bwc_entry_t        q_data,
    output logic              q_pop,
    input  logic [TEMP_W-1:0] hot_temp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_wake_reason,
    output logic              m_fast_sleep,
    output logic [POLL_W-1:0] m_poll_seconds,
    output logic [1:0]        m_band_now
);

    logic              valid_reg;
    logic [1:0]        reason_reg;
    logic              fast_reg;
    logic [POLL_W-1:0] poll_reg, poll_next;
    logic [1:0]        band_reg;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        poll_next = poll_lookup(q_data.volt);
        if ($signed(q_data.temp) >= $signed(hot_temp))
            poll_next = POLL_SECS_4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            reason_reg <= q_data.reason;
            fast_reg   <= (q_data.reason == WAKE_NONE);
            poll_reg   <= poll_next;
            band_reg   <= q_data.band;
        end
    end

    assign m_valid        = valid_reg;
    assign m_wake_reason  = reason_reg;
    assign m_fast_sleep   = fast_reg;
    assign m_poll_seconds = poll_reg;
    assign m_band_now     = band_reg;

endmodule

/* src/battery_wake_check_unit.sv */
// Battery wake check unit: top level tying front, queue and back parts.
// Depends on bwc_pkg, bwc_front, bwc_queue and bwc_back.
//
// Usage:
//   s_ channel: one battery reading per word (read_ok, charge_percent,
//   cell_voltage_uv, cell_temp_c), valid/ready handshake.
//   m_ channel: one result word per reading (wake_reason, fast_sleep,
//   poll_seconds, band_now), valid/ready handshake, same order as input.
//   cfg port: write cfg_wdata to register cfg_index while cfg_wr_en is high;
//   write only while no reading is in flight.
// Timing:
//   A reading is classified in the cycle it is accepted; its result goes
//   through the queue and the output register to m_valid. One word per
//   cycle is sustained while m_ready is high; the front's ring vote is combinational.
//   A two-word queue and the output register let the back part stall on
//   m_ready while the front keeps taking words until the queue fills.
// Reset:
//   aresetn low for one clock clears ring, stored state, queue and output;
//   registers return to their defaults. No clearing pass is needed.
module battery_wake_check_unit
    import bwc_pkg::*;
#(
    parameter int VOLTAGE_WINDOW = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_read_ok,
    input  logic [PCT_W-1:0]      s_charge_percent,
    input  logic [VOLT_W-1:0]     s_cell_voltage_uv,
    input  logic [TEMP_W-1:0]     s_cell_temp_c,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_wake_reason,
    output logic                  m_fast_sleep,
    output logic [POLL_W-1:0]     m_poll_seconds,
    output logic [1:0]            m_band_now
);

    localparam logic [$clog2(QUEUE_DEPTH+1)-1:0] Q_FULL = ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);

    bwc_entry_t        front_entry, q_data;
    logic              q_full, q_valid, q_pop, accept;
    logic [TEMP_W-1:0] hot_temp;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_fill;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    bwc_front #(
        .VOLTAGE_WINDOW(VOLTAGE_WINDOW)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .accept          (accept),
        .read_ok         (s_read_ok),
        .charge_percent  (s_charge_percent),
        .cell_voltage_uv (s_cell_voltage_uv),
        .cell_temp_c     (s_cell_temp_c),
        .entry           (front_entry),
        .hot_temp        (hot_temp)
    );

    bwc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (accept),
        .wr_data   (front_entry),
        .full      (q_full),
        .rd_en     (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_data),
        .fill      (q_fill)
    );

    bwc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .hot_temp       (hot_temp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_wake_reason  (m_wake_reason),
        .m_fast_sleep   (m_fast_sleep),
        .m_poll_seconds (m_poll_seconds),
        .m_band_now     (m_band_now)
    );

`ifndef SYNTH
    a_fast_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fast_sleep == (m_wake_reason == WAKE_NONE)))
        else $error("fast_sleep disagrees with wake_reason");

    a_poll_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_poll_seconds == POLL_SECS_0 || m_poll_seconds == POLL_SECS_1 ||
                     m_poll_seconds == POLL_SECS_2 || m_poll_seconds == POLL_SECS_3 ||
                     m_poll_seconds == POLL_SECS_4))
        else $error("poll_seconds outside table");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (q_fill == Q_FULL && m_valid))
        else $error("input stalled while queue not full");

    a_queue_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !m_valid) |=> m_valid)
        else $error("queued word not moved to output");
`endif

endmodule
